@@ rtl/dsfd_pkg.sv @@
`default_nettype none

package dsfd_pkg;

  localparam int HdrLen = 10;
  localparam int CrcLen = 8;
  localparam int BlockLen = 16;
  localparam int BlockBits = $clog2(BlockLen);

  localparam logic [7:0] SYNC_A = 8'h05;
  localparam logic [7:0] SYNC_B = 8'h64;
  localparam logic [7:0] MIN_LEN = 8'd5;
  localparam logic [15:0] CRC_POLY = 16'hA6BC;

  typedef logic [15:0] crc_table_t [256];

  function automatic crc_table_t build_crc_table();
    crc_table_t t;
    logic [15:0] c;
    for (int i = 0; i < 256; i++) begin
      c = 16'(i);
      for (int b = 0; b < 8; b++) begin
        if (c[0]) begin
          c = (c >> 1) ^ CRC_POLY;
        end else begin
          c = c >> 1;
        end
      end
      t[i] = c;
    end
    return t;
  endfunction

  localparam crc_table_t CRC_TABLE = build_crc_table();

  // Byte k of the header sits at bits [8k+7:8k].
  function automatic logic [15:0] crc_dnp_hdr(input logic [8*CrcLen-1:0] bytes);
    logic [15:0] c;
    logic [7:0] idx;
    c = '0;
    for (int k = 0; k < CrcLen; k++) begin
      idx = c[7:0] ^ bytes[8*k +: 8];
      c = (c >> 8) ^ CRC_TABLE[idx];
    end
    return ~c;
  endfunction

endpackage

`default_nettype wire

@@ rtl/dnp3_serial_frame_delineator_core.sv @@
// DNP3 serial link frame delineator.
// Raw serial bytes enter on the input channel (in_valid, in_stall, in_byte) one word at a
// time. The block hunts for a ten-byte link header that starts with 0x05 0x64, has a length
// of at least five and carries a matching CRC-16/DNP; windows that fail slide forward.
// Delineated frame bytes leave on the output channel (out_valid, out_stall, out_byte,
// frame_first, frame_last); frame_first marks the first sync byte and frame_last the final
// byte of each frame.
// Throughput is one word per cycle on both channels while in_stall and out_stall are low. A
// byte inside a frame is registered into the output word, or into the skid word if the output
// is stalled. When a header completes, burst_active is set and the ten header bytes are then
// replayed from the window through the output register; in_stall stays high for that burst.
// The output register is backed by one skid word, so a stalled result does not block the
// input until the skid word is also occupied; in_stall then stays high until the receiver
// takes a word. The header CRC is kept in a register that follows the window.
// A synchronous reset drops any partial window, any frame in progress and any queued words.

`default_nettype none

module dnp3_serial_frame_delineator_core import dsfd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       frame_first,
  output logic       frame_last
);

  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
  } word_t;

  logic [7:0]  window [HdrLen];
  logic [7:0]  window_next [HdrLen];
  logic [7:0]  cand [HdrLen];
  logic [3:0]  fill;
  logic [3:0]  fill_next;
  logic        in_frame;
  logic        in_frame_next;
  logic [8:0]  bytes_remaining;
  logic [8:0]  bytes_remaining_next;
  logic [15:0] crc;
  logic [8*CrcLen-1:0] crc_bytes;
  logic        burst_active;
  logic [3:0]  burst_idx;
  logic        burst_last;
  logic        burst_start;
  logic        skid_valid;
  logic        skid_valid_next;
  logic        out_valid_next;
  word_t       skid_word;
  word_t       out_word;
  word_t       push_word;
  logic        push;
  logic        accept;
  logic        taken;
  logic        header_ok;
  logic [7:0]  data_len;
  logic [8:0]  data_sum;
  logic [4:0]  blocks;
  logic [8:0]  new_rem;
  logic        found;
  logic [3:0]  shift;
  logic [4:0]  src;

  assign in_stall = skid_valid || burst_active;
  assign accept = in_valid && !in_stall;
  assign taken = out_valid && !out_stall;

  assign out_byte = out_word.data;
  assign frame_first = out_word.first;
  assign frame_last = out_word.last;

  always_comb begin
    for (int k = 0; k < CrcLen; k++) begin
      crc_bytes[8*k +: 8] = window[k];
    end
    for (int k = 0; k < HdrLen - 1; k++) begin
      cand[k] = window[k];
    end
    cand[HdrLen-1] = in_byte;
  end

  assign header_ok = (window[2] >= MIN_LEN) && (crc == {in_byte, window[HdrLen-2]});
  assign data_len = window[2] - MIN_LEN;
  assign data_sum = {1'b0, data_len} + 9'(BlockLen - 1);
  assign blocks = 5'(data_sum >> BlockBits);
  assign new_rem = {1'b0, data_len} + {3'b000, blocks, 1'b0};

  // The oldest two bytes were 0x05 0x64, so the next possible header starts at byte two or later.
  always_comb begin
    found = 1'b0;
    shift = '0;
    if (cand[HdrLen-1] == SYNC_A) begin
      found = 1'b1;
      shift = 4'(HdrLen - 1);
    end
    for (int j = HdrLen - 2; j >= 2; j--) begin
      if (cand[j] == SYNC_A && cand[j+1] == SYNC_B) begin
        found = 1'b1;
        shift = 4'(j);
      end
    end
  end

  always_comb begin
    src = '0;
    window_next = window;
    fill_next = fill;
    in_frame_next = in_frame;
    bytes_remaining_next = bytes_remaining;
    burst_start = 1'b0;
    push = 1'b0;
    push_word = '0;
    if (accept) begin
      if (in_frame) begin
        push = 1'b1;
        push_word.data = in_byte;
        push_word.last = (bytes_remaining == 9'd1);
        bytes_remaining_next = bytes_remaining - 9'd1;
        if (bytes_remaining == 9'd1) begin
          in_frame_next = 1'b0;
          fill_next = '0;
        end
      end else begin
        case (fill) inside
          4'd0: begin
            window_next[0] = in_byte;
            fill_next = (in_byte == SYNC_A) ? 4'd1 : 4'd0;
          end
          4'd1: begin
            if (in_byte == SYNC_B) begin
              window_next[1] = in_byte;
              fill_next = 4'd2;
            end else if (in_byte == SYNC_A) begin
              window_next[0] = in_byte;
              fill_next = 4'd1;
            end else begin
              fill_next = 4'd0;
            end
          end
          [4'd2:4'(HdrLen - 2)]: begin
            window_next[fill] = in_byte;
            fill_next = fill + 4'd1;
          end
          4'(HdrLen - 1): begin
            if (header_ok) begin
              window_next[HdrLen-1] = in_byte;
              fill_next = '0;
              burst_start = 1'b1;
              bytes_remaining_next = new_rem;
              in_frame_next = (new_rem != 9'd0);
            end else begin
              for (int k = 0; k < HdrLen - 2; k++) begin
                src = 5'(k) + {1'b0, shift};
                if (src < 5'(HdrLen)) begin
                  window_next[k] = cand[src[3:0]];
                end
              end
              fill_next = found ? 4'(HdrLen) - shift : 4'd0;
            end
          end
          default: begin
            fill_next = '0;
          end
        endcase
      end
    end else if (burst_active && !skid_valid) begin
      push = 1'b1;
      push_word.data = window[burst_idx];
      push_word.first = (burst_idx == 4'd0);
      push_word.last = (burst_idx == 4'(HdrLen - 1)) && burst_last;
    end
  end

  always_comb begin
    if (skid_valid) begin
      out_valid_next = 1'b1;
      skid_valid_next = !taken;
    end else begin
      out_valid_next = push || (out_valid && !taken);
      skid_valid_next = push && out_valid && !taken;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      in_frame <= 1'b0;
      bytes_remaining <= '0;
      burst_active <= 1'b0;
      burst_idx <= '0;
      skid_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      fill <= fill_next;
      in_frame <= in_frame_next;
      bytes_remaining <= bytes_remaining_next;
      skid_valid <= skid_valid_next;
      out_valid <= out_valid_next;
      if (burst_start) begin
        burst_active <= 1'b1;
        burst_idx <= '0;
      end else if (burst_active && !skid_valid) begin
        if (burst_idx == 4'(HdrLen - 1)) begin
          burst_active <= 1'b0;
        end else begin
          burst_idx <= burst_idx + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    window <= window_next;
    crc <= crc_dnp_hdr(crc_bytes);
    if (burst_start) begin
      burst_last <= (new_rem == 9'd0);
    end
    if (skid_valid) begin
      if (taken) begin
        out_word <= skid_word;
      end
    end else if (push) begin
      if (!out_valid || taken) begin
        out_word <= push_word;
      end else begin
        skid_word <= push_word;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/dsfd_checker.sv @@
`default_nettype none

module dsfd_checker import dsfd_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       frame_first,
  input logic       frame_last
);

  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("Output word present right after reset.");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(frame_first)
      && $stable(frame_last))
    else $error("Stalled output word changed.");

  a_first_is_sync: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_first |-> out_byte == SYNC_A && !frame_last)
    else $error("Frame start word is not a lone first sync byte.");

  a_header_follows: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && frame_first |=> in_stall
      && (!out_valid || (out_byte == SYNC_B && !frame_first)))
    else $error("Header burst did not continue after its first word.");

endmodule

bind dnp3_serial_frame_delineator_core dsfd_checker u_dsfd_checker (
  .clk(clk),
  .rst(rst),
  .in_stall(in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_byte(out_byte),
  .frame_first(frame_first),
  .frame_last(frame_last)
);

`default_nettype wire

@@ test/dnp3_serial_frame_delineator_core_tb.sv @@
module dnp3_serial_frame_delineator_core_tb;
  import dsfd_pkg::*;

  localparam int NoCheck = -1;
  localparam int HoldCycles = 200;
  localparam int WatchdogLimit = 4000;
  localparam int DirRows = 24;

  typedef enum logic [1:0] {ROW_RAW, ROW_CRC_LO, ROW_CRC_HI} row_kind_t;

  typedef struct {
    row_kind_t  kind;
    logic [7:0] val;
    int         n_exp;
    logic       last_exp;
  } dir_row_t;

  typedef struct {
    logic [7:0] data;
    logic       first;
    logic       last;
  } frame_word_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_byte;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_byte;
  logic       frame_first;
  logic       frame_last;

  frame_word_t frame_words_due[$];
  logic [7:0]  pending_bytes[$];
  dir_row_t    dir_rows [DirRows];

  logic [7:0] hunt_win [HdrLen];
  int         hunt_fill;
  logic       frame_open;
  logic [8:0] frame_left;

  int  src_idle_pct;
  int  recv_idle_pct;
  bit  hold_req;
  int  mismatch_count;
  int  idle_cycles;

  dnp3_serial_frame_delineator_core i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_byte     (in_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .frame_first (frame_first),
    .frame_last  (frame_last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [15:0] link_crc(input logic [63:0] hdr);
    logic [15:0] c;
    c = '0;
    for (int k = 0; k < CrcLen; k++) begin
      c = c ^ {8'h00, hdr[8*k +: 8]};
      for (int j = 0; j < 8; j++) begin
        c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
    end
    return ~c;
  endfunction

  function automatic logic [8:0] frame_tail_len(input logic [7:0] len);
    int data_n;
    data_n = int'(len) - int'(MIN_LEN);
    return 9'(data_n + 2 * ((data_n + BlockLen - 1) / BlockLen));
  endfunction

  function automatic void shift_window();
    if (hunt_fill != 0) begin
      for (int k = 0; k < HdrLen - 1; k++) begin
        hunt_win[k] = hunt_win[k + 1];
      end
      hunt_win[HdrLen - 1] = 8'h00;
      hunt_fill--;
    end
  endfunction

  task automatic delineate_byte(input logic [7:0] b, output int n, output logic tail);
    logic [63:0] hdr;
    logic [15:0] got;
    logic        done;
    n = 0;
    tail = 1'b0;
    if (frame_open) begin
      if (frame_left != 0) begin
        frame_left--;
      end
      tail = (frame_left == 0);
      frame_words_due.push_back('{data: b, first: 1'b0, last: tail});
      n = 1;
      if (tail) begin
        frame_open = 1'b0;
        hunt_fill = 0;
      end
    end else begin
      if (hunt_fill >= HdrLen) begin
        shift_window();
      end
      hunt_win[hunt_fill] = b;
      hunt_fill++;
      done = 1'b0;
      while (!done) begin
        if ((hunt_fill >= 1 && hunt_win[0] != SYNC_A) ||
            (hunt_fill >= 2 && hunt_win[1] != SYNC_B)) begin
          shift_window();
        end else if (hunt_fill < HdrLen) begin
          done = 1'b1;
        end else begin
          for (int k = 0; k < CrcLen; k++) begin
            hdr[8*k +: 8] = hunt_win[k];
          end
          got = {hunt_win[9], hunt_win[8]};
          if (hunt_win[2] < MIN_LEN || got != link_crc(hdr)) begin
            shift_window();
          end else begin
            frame_left = frame_tail_len(hunt_win[2]);
            for (int k = 0; k < HdrLen; k++) begin
              tail = (k == HdrLen - 1) && (frame_left == 0);
              frame_words_due.push_back('{data: hunt_win[k], first: (k == 0), last: tail});
            end
            n = HdrLen;
            hunt_fill = 0;
            frame_open = (frame_left != 0);
            done = 1'b1;
          end
        end
      end
    end
  endtask

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_word(input logic [7:0] b, output int n, output logic tail);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    delineate_byte(b, n, tail);
    @(negedge clk);
  endtask

  task automatic append_frame(input logic [7:0] len, input bit bad_crc);
    logic [63:0] hdr;
    logic [15:0] crc;
    hdr[7:0] = SYNC_A;
    hdr[15:8] = SYNC_B;
    hdr[23:16] = len;
    for (int k = 3; k < CrcLen; k++) begin
      hdr[8*k +: 8] = 8'($urandom);
    end
    crc = link_crc(hdr);
    if (bad_crc) begin
      crc = crc ^ (16'h0001 << $urandom_range(15));
    end
    for (int k = 0; k < CrcLen; k++) begin
      pending_bytes.push_back(hdr[8*k +: 8]);
    end
    pending_bytes.push_back(crc[7:0]);
    pending_bytes.push_back(crc[15:8]);
    if (!bad_crc && len >= MIN_LEN) begin
      repeat (int'(frame_tail_len(len))) begin
        pending_bytes.push_back(8'($urandom));
      end
    end
  endtask

  task automatic run_random(input int src_pct, input int recv_pct, input int count,
                            input bit lead_long);
    int         sent;
    int         pick;
    int         r;
    int         keep;
    int         n;
    logic       tail;
    logic [7:0] len;
    src_idle_pct = src_pct;
    recv_idle_pct = recv_pct;
    sent = 0;
    while (sent < count) begin
      pending_bytes.delete();
      pick = $urandom_range(99);
      if (lead_long) begin
        append_frame(8'd100, 1'b0);
        lead_long = 1'b0;
      end else if (pick < 70) begin
        r = $urandom_range(99);
        if (r < 5) begin
          len = 8'($urandom_range(4, 0));
        end else if (r < 80) begin
          len = 8'($urandom_range(24, 5));
        end else if (r < 97) begin
          len = 8'($urandom_range(60, 25));
        end else begin
          len = 8'($urandom_range(255, 200));
        end
        append_frame(len, 1'b0);
      end else if (pick < 85) begin
        repeat ($urandom_range(6, 1)) begin
          r = $urandom_range(3);
          pending_bytes.push_back(r == 0 ? SYNC_A : (r == 1 ? SYNC_B : 8'($urandom)));
        end
      end else begin
        append_frame(8'($urandom_range(24, 5)), 1'b1);
        if ($urandom_range(1) == 1) begin
          keep = $urandom_range(9, 2);
          while (pending_bytes.size() > keep) begin
            void'(pending_bytes.pop_back());
          end
        end
      end
      foreach (pending_bytes[k]) begin
        send_word(pending_bytes[k], n, tail);
        sent++;
      end
    end
  endtask

  initial begin : receiver
    int hold_left;
    hold_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = HoldCycles;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    frame_word_t want;
    if (!rst && out_valid && !out_stall) begin
      if (frame_words_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected word: byte %h first %b last %b", out_byte, frame_first,
                   frame_last);
        end
      end else begin
        want = frame_words_due.pop_front();
        if (out_byte !== want.data || frame_first !== want.first ||
            frame_last !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("word mismatch: expected byte %h first %b last %b, got %h %b %b",
                     want.data, want.first, want.last, out_byte, frame_first, frame_last);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [63:0] hdr;
    logic [15:0] crc;
    logic [7:0]  dir_bytes [DirRows];
    int          n;
    logic        tail;
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_byte <= 8'h00;
    src_idle_pct = 38;
    recv_idle_pct = 47;
    hold_req = 1'b0;
    mismatch_count = 0;
    hunt_win = '{default: 8'h00};
    hunt_fill = 0;
    frame_open = 1'b0;
    frame_left = '0;

    // A minimal frame, a header whose length is below five, then a partial prefix.
    dir_rows = '{
      '{ROW_RAW,    8'h00, 0,       1'b0},
      '{ROW_RAW,    8'h05, NoCheck, 1'b0},
      '{ROW_RAW,    8'h64, NoCheck, 1'b0},
      '{ROW_RAW,    8'h05, NoCheck, 1'b0},
      '{ROW_RAW,    8'hC0, NoCheck, 1'b0},
      '{ROW_RAW,    8'h01, NoCheck, 1'b0},
      '{ROW_RAW,    8'h00, NoCheck, 1'b0},
      '{ROW_RAW,    8'h00, NoCheck, 1'b0},
      '{ROW_RAW,    8'h04, NoCheck, 1'b0},
      '{ROW_CRC_LO, 8'h00, NoCheck, 1'b0},
      '{ROW_CRC_HI, 8'h00, 10,      1'b1},
      '{ROW_RAW,    8'h05, NoCheck, 1'b0},
      '{ROW_RAW,    8'h64, NoCheck, 1'b0},
      '{ROW_RAW,    8'h04, NoCheck, 1'b0},
      '{ROW_RAW,    8'hFF, NoCheck, 1'b0},
      '{ROW_RAW,    8'hFF, NoCheck, 1'b0},
      '{ROW_RAW,    8'hFF, NoCheck, 1'b0},
      '{ROW_RAW,    8'hFF, NoCheck, 1'b0},
      '{ROW_RAW,    8'hFF, NoCheck, 1'b0},
      '{ROW_CRC_LO, 8'h00, NoCheck, 1'b0},
      '{ROW_CRC_HI, 8'h00, 0,       1'b0},
      '{ROW_RAW,    8'h05, 0,       1'b0},
      '{ROW_RAW,    8'h05, 0,       1'b0},
      '{ROW_RAW,    8'h64, 0,       1'b0}
    };
    for (int i = 0; i < DirRows; i++) begin
      if (dir_rows[i].kind == ROW_RAW) begin
        dir_bytes[i] = dir_rows[i].val;
      end else begin
        for (int k = 0; k < CrcLen; k++) begin
          hdr[8*k +: 8] = (dir_rows[i].kind == ROW_CRC_LO) ? dir_bytes[i - 8 + k]
                                                            : dir_bytes[i - 9 + k];
        end
        crc = link_crc(hdr);
        dir_bytes[i] = (dir_rows[i].kind == ROW_CRC_LO) ? crc[7:0] : crc[15:8];
      end
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < DirRows; i++) begin
      send_word(dir_bytes[i], n, tail);
      if (dir_rows[i].n_exp != NoCheck &&
          (n != dir_rows[i].n_exp || tail != dir_rows[i].last_exp)) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("row %0d: expected %0d words last %b, predicted %0d last %b", i,
                   dir_rows[i].n_exp, dir_rows[i].last_exp, n, tail);
        end
      end
    end

    run_random(38, 47, 60, 1'b0);
    run_random(47, 38, 60, 1'b0);
    // The receiver holds off while a long frame keeps arriving.
    hold_req = 1'b1;
    run_random(0, 0, 100, 1'b1);
    in_valid <= 1'b0;

    while (frame_words_due.size() != 0) begin
      @(negedge clk);
    end
    repeat (20) @(negedge clk);

    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
